### rtl/bsl_pkg.sv
// Shared types and constants for the byte stream lexer.
`timescale 1ns / 1ps

package bsl_pkg;

  // Character codes that the scanner looks for.
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0a;
  localparam logic [7:0] ChEnd   = 8'h00;

  // Token kind codes.
  localparam logic [2:0] KindSkip   = 3'd0;
  localparam logic [2:0] KindWs     = 3'd1;
  localparam logic [2:0] KindSingle = 3'd2;
  localparam logic [2:0] KindIdent  = 3'd3;
  localparam logic [2:0] KindNum    = 3'd4;
  localparam logic [2:0] KindStr    = 3'd5;
  localparam logic [2:0] KindEnd    = 3'd6;

  // Error codes carried on the end word.
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrString  = 2'd1;
  localparam logic [1:0] ErrComment = 2'd2;

  // Result queue depth; one accepted byte pushes at most two words.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       starts_token;
    logic       keep_byte;
    logic [1:0] error_code;
    logic       last;
  } result_t;

  // Words produced by the scanner for one input byte.
  typedef struct packed {
    result_t    res0;
    result_t    res1;
    logic [1:0] count;
  } scan_out_t;

endpackage

### rtl/bsl_if.sv
// Valid/ready channel interfaces for the input byte and the result words.
`timescale 1ns / 1ps

interface bsl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface bsl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] kind;
  logic       starts_token;
  logic       keep_byte;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output kind, output starts_token,
                  output keep_byte, output error_code, output last, input ready);
  modport sink (input valid, input out_byte, input kind, input starts_token,
                input keep_byte, input error_code, input last, output ready);
endinterface

### rtl/bsl_scan.sv
// Scan mode register and per-byte classification into zero, one or two result words.
`timescale 1ns / 1ps

module bsl_scan import bsl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  output scan_out_t  scan_o
);

  typedef enum logic [3:0] {
    ModeIdle    = 4'd0,
    ModeWs      = 4'd1,
    ModeIdent   = 4'd2,
    ModeNum     = 4'd3,
    ModeNumDot  = 4'd4,
    ModeStr     = 4'd5,
    ModeStrQ    = 4'd6,
    ModeMinus   = 4'd7,
    ModeComment = 4'd8
  } mode_e;

  mode_e mode_q, mode_d;

  function automatic result_t mk(logic [7:0] b, logic [2:0] k, logic st, logic kp,
                                 logic [1:0] err);
    result_t r;
    r.out_byte     = b;
    r.kind         = k;
    r.starts_token = st;
    r.keep_byte    = kp;
    r.error_code   = err;
    r.last         = 1'b0;
    return r;
  endfunction

  // Character classes of the incoming byte.
  logic is_ws, is_digit, is_alpha, is_end, is_quote, is_minus;
  assign is_ws    = (byte_i == ChSpace) || (byte_i == ChTab) || (byte_i == ChNl);
  assign is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign is_alpha = ((byte_i >= 8'h61) && (byte_i <= 8'h7a)) ||
                    ((byte_i >= 8'h41) && (byte_i <= 8'h5a)) || (byte_i == ChUnder);
  assign is_end   = (byte_i == ChEnd);
  assign is_quote = (byte_i == ChQuote);
  assign is_minus = (byte_i == ChMinus);

  // Handling of a byte that arrives between tokens.
  result_t f_res;
  logic    f_emit;
  mode_e   f_mode;
  always_comb begin
    f_emit = 1'b1;
    f_res  = mk(byte_i, KindSingle, 1'b1, 1'b1, ErrNone);
    f_mode = ModeIdle;
    if (is_end) begin
      f_res = mk(ChEnd, KindEnd, 1'b1, 1'b0, ErrNone);
    end else if (is_ws) begin
      f_res  = mk(byte_i, KindWs, 1'b1, 1'b0, ErrNone);
      f_mode = ModeWs;
    end else if (is_quote) begin
      f_res  = mk(byte_i, KindStr, 1'b1, 1'b0, ErrNone);
      f_mode = ModeStr;
    end else if (is_alpha) begin
      f_res  = mk(byte_i, KindIdent, 1'b1, 1'b1, ErrNone);
      f_mode = ModeIdent;
    end else if (is_digit) begin
      f_res  = mk(byte_i, KindNum, 1'b1, 1'b1, ErrNone);
      f_mode = ModeNum;
    end else if (is_minus) begin
      f_emit = 1'b0;
      f_mode = ModeMinus;
    end
  end

  // Mode-dependent results and next mode.
  result_t r0, r1;
  logic [1:0] cnt;
  always_comb begin
    r0     = f_res;
    r1     = f_res;
    cnt    = {1'b0, f_emit};
    mode_d = f_mode;
    unique case (mode_q)
      ModeComment: begin
        cnt = 2'd1;
        if (is_end) begin
          r0     = mk(ChEnd, KindEnd, 1'b1, 1'b0, ErrComment);
          mode_d = ModeIdle;
        end else begin
          r0     = mk(byte_i, KindSkip, 1'b0, 1'b0, ErrNone);
          mode_d = (byte_i == ChNl) ? ModeIdle : ModeComment;
        end
      end
      ModeStr: begin
        cnt = 2'd1;
        if (is_end) begin
          r0     = mk(ChEnd, KindEnd, 1'b1, 1'b0, ErrString);
          mode_d = ModeIdle;
        end else if (is_quote) begin
          r0     = mk(byte_i, KindStr, 1'b0, 1'b0, ErrNone);
          mode_d = ModeStrQ;
        end else begin
          r0     = mk(byte_i, KindStr, 1'b0, 1'b1, ErrNone);
          mode_d = ModeStr;
        end
      end
      ModeStrQ: begin
        if (is_quote) begin
          r0     = mk(byte_i, KindStr, 1'b0, 1'b1, ErrNone);
          cnt    = 2'd1;
          mode_d = ModeStr;
        end
      end
      ModeMinus: begin
        cnt = 2'd2;
        if (is_minus) begin
          r0     = mk(ChMinus, KindSkip, 1'b0, 1'b0, ErrNone);
          r1     = mk(byte_i, KindSkip, 1'b0, 1'b0, ErrNone);
          mode_d = ModeComment;
        end else begin
          // Flush the held minus, then handle this byte from scratch.
          r0 = mk(ChMinus, KindSingle, 1'b1, 1'b1, ErrNone);
        end
      end
      ModeWs: begin
        if (is_ws) begin
          r0     = mk(byte_i, KindWs, 1'b0, 1'b0, ErrNone);
          cnt    = 2'd1;
          mode_d = ModeWs;
        end
      end
      ModeIdent: begin
        if (is_alpha || is_digit) begin
          r0     = mk(byte_i, KindIdent, 1'b0, 1'b1, ErrNone);
          cnt    = 2'd1;
          mode_d = ModeIdent;
        end
      end
      ModeNum: begin
        if (is_digit || (byte_i == ChDot)) begin
          r0     = mk(byte_i, KindNum, 1'b0, 1'b1, ErrNone);
          cnt    = 2'd1;
          mode_d = is_digit ? ModeNum : ModeNumDot;
        end
      end
      ModeNumDot: begin
        if (is_digit) begin
          r0     = mk(byte_i, KindNum, 1'b0, 1'b1, ErrNone);
          cnt    = 2'd1;
          mode_d = ModeNumDot;
        end
      end
      default: begin
        // Idle, and any code outside the mode set, start from scratch.
      end
    endcase
    // Flag the final word of this byte.
    if (cnt == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

  assign scan_o.res0  = r0;
  assign scan_o.res1  = r1;
  assign scan_o.count = cnt;

  // Scan mode advances only on an accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
    end else if (take_i) begin
      mode_q <= mode_d;
    end
  end

endmodule

### rtl/byte_stream_lexer.sv
// Top level of the byte stream lexer: scanner plus result word queue.
//
// Usage: source bytes enter on in_i, one word per accepted byte, byte 0
// marking the end of a stream. Result words leave on out_o; each byte yields
// zero words (a minus held for one byte), one word, or two words (a flushed
// minus followed by the new byte, or the two bytes that open a comment).
// The last flag marks the final word that a byte produced.
// The words of an accepted byte are written into the queue, and out_o is
// driven from its head. Throughput: one byte per cycle while each byte yields
// at most one word and out_o is not stalled; a two-word byte needs two transfers.
// The scanner classifies every byte from the scan mode register; words wait
// in a four-entry queue, and in_i.ready is high while two entries are free,
// so a stalled receiver backs up into in_i with nothing lost. Reset empties
// the queue and returns the scanner to idle between tokens. After an end
// word the scanner is idle again, ready for a new stream.
`timescale 1ns / 1ps

module byte_stream_lexer import bsl_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  bsl_in_if.sink    in_i,
  bsl_out_if.source out_o
);

  scan_out_t scan;
  logic      take;
  logic      pop;

  result_t          q_mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  result_t          head;

  assign take       = in_i.valid && in_i.ready;
  assign in_i.ready = (cnt_q <= QCntW'(QDepth - 2));
  assign pop        = out_o.valid && out_o.ready;

  bsl_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (in_i.in_byte),
    .scan_o (scan)
  );

  // Queue occupancy.
  always_comb begin
    cnt_d = cnt_q;
    if (take) begin
      cnt_d = cnt_d + QCntW'(scan.count);
    end
    if (pop) begin
      cnt_d = cnt_d - QCntW'(1);
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (take) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(scan.count);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  // Queue storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      q_mem[wr_ptr_q] <= scan.res0;
      if (scan.count == 2'd2) begin
        q_mem[wr_ptr_q + QPtrW'(1)] <= scan.res1;
      end
    end
  end

  // Head of the queue drives the output word.
  assign head               = q_mem[rd_ptr_q];
  assign out_o.valid        = (cnt_q != '0);
  assign out_o.out_byte     = head.out_byte;
  assign out_o.kind         = head.kind;
  assign out_o.starts_token = head.starts_token;
  assign out_o.keep_byte    = head.keep_byte;
  assign out_o.error_code   = head.error_code;
  assign out_o.last         = head.last;

  // The queue never holds more words than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  // A byte that yields words makes the output valid on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (take && scan.count != 2'd0) |=> out_o.valid)
    else $error("produced word did not reach the output");

  // An end word opens a token, keeps no text and closes its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_o.valid && out_o.kind == KindEnd) |->
                   (out_o.starts_token && !out_o.keep_byte && out_o.last))
    else $error("malformed end word");

  // Errors appear only on end words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_o.valid && out_o.error_code != ErrNone) |-> out_o.kind == KindEnd)
    else $error("error flagged on a non-end word");

endmodule

### tb/tb.sv
// Self-checking testbench for the byte stream lexer: random source text against a token predictor.
`timescale 1ns / 1ps

module tb import bsl_pkg::*; ();

  // Scanner modes tracked by the predictor.
  typedef enum logic [3:0] {
    ModeIdle,
    ModeWs,
    ModeIdent,
    ModeNum,
    ModeNumDot,
    ModeStr,
    ModeStrQuote,
    ModeMinus,
    ModeComment
  } scan_mode_e;

  // One source byte waiting to be sent; drain makes the sender wait for an empty scoreboard.
  typedef struct packed {
    logic       drain;
    logic [7:0] value;
  } src_byte_t;

  localparam int RandomBytes = 850;
  localparam int IdleLimit   = 2000;
  localparam int TailCycles  = 20;
  localparam int ReportMax   = 10;

  logic clk_i;
  logic rst_ni;

  bsl_in_if  in_if ();
  bsl_out_if out_if ();

  byte_stream_lexer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  src_byte_t  source_text[$];
  result_t    expected_tokens[$];
  result_t    token_batch[2];
  int         batch_len;
  scan_mode_e scan_state;

  int   total_bytes;
  int   bytes_accepted;
  int   mismatches;
  int   idle_cycles;
  int   send_gap;
  int   stall_left;
  logic in_taken;
  logic burst_mode;

  // Character classes.
  function automatic logic is_space(input logic [7:0] b);
    return b == ChSpace || b == ChTab || b == ChNl;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == ChUnder;
  endfunction

  // Append one predicted word for the byte under way.
  function automatic void add_token(input logic [7:0] b, input logic [2:0] k,
                                    input logic st, input logic kp,
                                    input logic [1:0] err);
    result_t r;
    r.out_byte     = b;
    r.kind         = k;
    r.starts_token = st;
    r.keep_byte    = kp;
    r.error_code   = err;
    r.last         = 1'b0;
    token_batch[batch_len] = r;
    batch_len++;
  endfunction

  // A byte that arrives between tokens opens a new one.
  function automatic void open_token(input logic [7:0] b);
    if (b == ChEnd) begin
      add_token(ChEnd, KindEnd, 1'b1, 1'b0, ErrNone);
      scan_state = ModeIdle;
    end else if (is_space(b)) begin
      add_token(b, KindWs, 1'b1, 1'b0, ErrNone);
      scan_state = ModeWs;
    end else if (b == ChQuote) begin
      add_token(b, KindStr, 1'b1, 1'b0, ErrNone);
      scan_state = ModeStr;
    end else if (is_letter(b)) begin
      add_token(b, KindIdent, 1'b1, 1'b1, ErrNone);
      scan_state = ModeIdent;
    end else if (is_digit(b)) begin
      add_token(b, KindNum, 1'b1, 1'b1, ErrNone);
      scan_state = ModeNum;
    end else if (b == ChMinus) begin
      scan_state = ModeMinus;
    end else begin
      add_token(b, KindSingle, 1'b1, 1'b1, ErrNone);
      scan_state = ModeIdle;
    end
  endfunction

  // Predict the words for one accepted byte and queue them.
  function automatic void lex_byte(input logic [7:0] b);
    result_t r;
    batch_len = 0;
    case (scan_state)
      ModeComment: begin
        if (b == ChEnd) begin
          add_token(ChEnd, KindEnd, 1'b1, 1'b0, ErrComment);
          scan_state = ModeIdle;
        end else begin
          add_token(b, KindSkip, 1'b0, 1'b0, ErrNone);
          if (b == ChNl) scan_state = ModeIdle;
        end
      end
      ModeStr: begin
        if (b == ChEnd) begin
          add_token(ChEnd, KindEnd, 1'b1, 1'b0, ErrString);
          scan_state = ModeIdle;
        end else if (b == ChQuote) begin
          add_token(b, KindStr, 1'b0, 1'b0, ErrNone);
          scan_state = ModeStrQuote;
        end else begin
          add_token(b, KindStr, 1'b0, 1'b1, ErrNone);
        end
      end
      ModeStrQuote: begin
        if (b == ChQuote) begin
          add_token(b, KindStr, 1'b0, 1'b1, ErrNone);
          scan_state = ModeStr;
        end else begin
          open_token(b);
        end
      end
      ModeMinus: begin
        if (b == ChMinus) begin
          add_token(ChMinus, KindSkip, 1'b0, 1'b0, ErrNone);
          add_token(b, KindSkip, 1'b0, 1'b0, ErrNone);
          scan_state = ModeComment;
        end else begin
          add_token(ChMinus, KindSingle, 1'b1, 1'b1, ErrNone);
          open_token(b);
        end
      end
      ModeWs: begin
        if (is_space(b)) add_token(b, KindWs, 1'b0, 1'b0, ErrNone);
        else open_token(b);
      end
      ModeIdent: begin
        if (is_letter(b) || is_digit(b)) add_token(b, KindIdent, 1'b0, 1'b1, ErrNone);
        else open_token(b);
      end
      ModeNum: begin
        if (is_digit(b)) begin
          add_token(b, KindNum, 1'b0, 1'b1, ErrNone);
        end else if (b == ChDot) begin
          add_token(b, KindNum, 1'b0, 1'b1, ErrNone);
          scan_state = ModeNumDot;
        end else begin
          open_token(b);
        end
      end
      ModeNumDot: begin
        if (is_digit(b)) add_token(b, KindNum, 1'b0, 1'b1, ErrNone);
        else open_token(b);
      end
      default: begin
        open_token(b);
      end
    endcase
    // Only the final word of this byte carries the last flag.
    for (int i = 0; i < batch_len; i++) begin
      r = token_batch[i];
      r.last = (i == batch_len - 1);
      expected_tokens.push_back(r);
    end
  endfunction

  // Source text generation.
  function automatic void add_byte(input logic [7:0] b, input logic drain = 1'b0);
    src_byte_t s;
    s.drain = drain;
    s.value = b;
    source_text.push_back(s);
  endfunction

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return ChUnder;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_ident_char();
    if ($urandom_range(0, 3) == 0) return pick_digit();
    return pick_letter();
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 2))
      0: return ChSpace;
      1: return ChTab;
      default: return ChNl;
    endcase
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 7))
      0: return "(";
      1: return ")";
      2: return ";";
      3: return "+";
      4: return "*";
      5: return ".";
      6: return ":";
      default: return "=";
    endcase
  endfunction

  // One random fragment of source text; mostly well-formed tokens, some noise.
  function automatic void add_fragment(input logic drain);
    int          sel;
    int          len;
    logic [7:0]  c;
    sel = $urandom_range(0, 99);
    if (sel < 18) begin
      add_byte(pick_letter(), drain);
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) add_byte(pick_ident_char());
    end else if (sel < 32) begin
      add_byte(pick_digit(), drain);
      len = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) add_byte(pick_digit());
      if ($urandom_range(0, 1) == 1) begin
        add_byte(ChDot);
        len = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) add_byte(pick_digit());
        if ($urandom_range(0, 4) == 0) add_byte(ChDot);
      end
    end else if (sel < 44) begin
      // A quote in the text is always doubled so the string stays open.
      add_byte(ChQuote, drain);
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        c = 8'($urandom_range(1, 255));
        add_byte(c);
        if (c == ChQuote) add_byte(ChQuote);
      end
      add_byte(ChQuote);
    end else if (sel < 56) begin
      add_byte(pick_space(), drain);
      len = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) add_byte(pick_space());
    end else if (sel < 64) begin
      add_byte(ChMinus, drain);
      add_byte(ChMinus);
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        c = 8'($urandom_range(1, 255));
        if (c == ChNl) c = ChSpace;
        add_byte(c);
      end
      add_byte(ChNl);
    end else if (sel < 72) begin
      add_byte(ChMinus, drain);
    end else if (sel < 80) begin
      add_byte(pick_punct(), drain);
    end else if (sel < 92) begin
      add_byte(8'($urandom_range(1, 255)), drain);
    end else if (sel < 96) begin
      add_byte(ChEnd, drain);
    end else begin
      // Stream cut off inside a string or a comment.
      if ($urandom_range(0, 1) == 1) begin
        add_byte(ChQuote, drain);
      end else begin
        add_byte(ChMinus, drain);
        add_byte(ChMinus);
      end
      len = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) add_byte(pick_letter());
      add_byte(ChEnd);
    end
  endfunction

  // Idle lengths: mostly short, a few long, none during a burst.
  function automatic int pick_idle();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sender: offers the next source byte at the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_taken) begin
      // Hold the current word until it is taken.
    end else if (send_gap > 0) begin
      send_gap    <= send_gap - 1;
      in_if.valid <= 1'b0;
    end else if (source_text.size() != 0 &&
                 !(source_text[0].drain && expected_tokens.size() != 0)) begin
      in_if.valid   <= 1'b1;
      in_if.in_byte <= source_text[0].value;
      void'(source_text.pop_front());
      send_gap <= pick_idle();
      if ($urandom_range(0, 63) == 0) burst_mode <= ~burst_mode;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Receiver: random stalls on the result channel.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_idle();
    end
  end

  // Predict on accepted bytes and check each accepted result word.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        lex_byte(in_if.in_byte);
        bytes_accepted <= bytes_accepted + 1;
      end
      if (out_if.valid && out_if.ready) begin
        got.out_byte     = out_if.out_byte;
        got.kind         = out_if.kind;
        got.starts_token = out_if.starts_token;
        got.keep_byte    = out_if.keep_byte;
        got.error_code   = out_if.error_code;
        got.last         = out_if.last;
        if (expected_tokens.size() == 0) begin
          if (mismatches < ReportMax)
            $display("unexpected result word: byte %02h kind %0d start %b keep %b err %0d last %b",
                     got.out_byte, got.kind, got.starts_token, got.keep_byte,
                     got.error_code, got.last);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_tokens.pop_front();
          if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
              got.starts_token !== want.starts_token || got.keep_byte !== want.keep_byte ||
              got.error_code !== want.error_code || got.last !== want.last) begin
            if (mismatches < ReportMax) begin
              $display("mismatch: expected byte %02h kind %0d start %b keep %b err %0d last %b",
                       want.out_byte, want.kind, want.starts_token, want.keep_byte,
                       want.error_code, want.last);
              $display("          actual   byte %02h kind %0d start %b keep %b err %0d last %b",
                       got.out_byte, got.kind, got.starts_token, got.keep_byte,
                       got.error_code, got.last);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Stimulus, reset and end of run.
  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.in_byte  = 8'h00;
    out_if.ready   = 1'b0;
    in_taken       = 1'b0;
    burst_mode     = 1'b0;
    send_gap       = 0;
    stall_left     = 0;
    bytes_accepted = 0;
    mismatches     = 0;
    idle_cycles    = 0;
    scan_state     = ModeIdle;

    // Directed text: identifier, whitespace, number with a second dot.
    add_byte("a");
    add_byte("9");
    add_byte(ChSpace);
    add_byte("1");
    add_byte(ChDot);
    add_byte("5");
    add_byte(ChDot);
    // String with a doubled quote, closed by a high byte.
    add_byte(ChQuote);
    add_byte("x");
    add_byte(ChQuote);
    add_byte(ChQuote);
    add_byte(ChQuote);
    add_byte(8'hff);
    // Held minus flushed before an identifier, then a comment through its newline.
    add_byte(ChMinus);
    add_byte("z");
    add_byte(ChMinus);
    add_byte(ChMinus);
    add_byte(ChNl);
    // Held minus flushed before the end byte.
    add_byte(ChMinus);
    add_byte(ChEnd);
    // End inside an open string, then inside a comment.
    add_byte(ChQuote);
    add_byte(ChEnd);
    add_byte(ChMinus);
    add_byte(ChMinus);
    add_byte(ChEnd);

    // Random text; the sender drains the scoreboard now and then.
    while (source_text.size() < 25 + RandomBytes)
      add_fragment(source_text.size() == 25 || $urandom_range(0, 99) == 0);
    total_bytes = source_text.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!(bytes_accepted == total_bytes && expected_tokens.size() == 0) &&
           idle_cycles < IdleLimit)
      @(posedge clk_i);

    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
    end else begin
      repeat (TailCycles) @(posedge clk_i);
      if (mismatches == 0 && expected_tokens.size() == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
    end
    $finish;
  end

endmodule
